// ----- hw/rtl/ktwp_pkg.sv -----
// Shared types and constants for the keyed table weighted pick block.
`default_nettype none
package ktwp_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned TotW   = 27;
  localparam int unsigned RandW  = 31;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BEST  = 2'd1,
    OP_RAND  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_MISSING     = 2'd1,
    ST_ZERO_WEIGHT = 2'd2,
    ST_WRITTEN     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IdxW-1:0]  slot;
    logic [63:0]      search_key;
    logic [15:0]      payload;
    logic [15:0]      entry_weight;
    logic [RandW-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     chosen_payload;
    logic [15:0]     chosen_weight;
    logic [IdxW-1:0] chosen_index;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] payload;
    logic [15:0] weight;
  } entry_t;

  typedef struct packed {
    logic            done;
    logic [TotW-1:0] rem;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ktwp_mem.sv -----
// Entry memory with one write port and one registered read port.
`default_nettype none
module ktwp_mem
  import ktwp_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ktwp_div.sv -----
// Restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module ktwp_div
  import ktwp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RandW-1:0] dividend,
  input  wire logic [TotW-1:0]  divisor,
  output div_stat_t             stat
);

  logic [RandW-1:0] dvd;
  logic [TotW-1:0]  dvs;
  logic [TotW-1:0]  rem;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [TotW:0]    trial;
  logic [TotW:0]    diff;

  assign trial = {rem, dvd[RandW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 5'(RandW);
    end else begin
      done <= busy && (cnt == 5'd1);
      if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[RandW-2:0], 1'b0};
      rem <= diff[TotW] ? trial[TotW-1:0] : diff[TotW-1:0];
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

endmodule
`default_nettype wire

// ----- hw/rtl/keyed_table_weighted_pick.sv -----
// Top level: sorted key table with binary search and weighted selection.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_item (in_item_t)
//   out     | output    | out_valid/out_stall | out_item (out_item_t)
//   cfg     | input     | cfg_we              | cfg_wdata (entry_count)
//
// A write item, an unused opcode or a query on an empty table is answered in the
// cycle after it is accepted.
// A query makes each memory read in a read state and a check state, for the
// binary search, to back up to the first entry of the run, over each entry of
// the run, and in random mode after the remainder unit for each bin scanned.
// All reads go through the single read port of the entry memory.
// Reset clears entry_count and control state; table contents stay undefined.
`default_nettype none
module keyed_table_weighted_pick
  import ktwp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_item,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_wdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CAP = (TABLE_DEPTH > 1024) ? 1024 : TABLE_DEPTH;

  typedef enum logic [10:0] {
    IDLE  = 11'b00000000001,
    S_RD  = 11'b00000000010,
    S_CHK = 11'b00000000100,
    B_RD  = 11'b00000001000,
    B_CHK = 11'b00000010000,
    W_RD  = 11'b00000100000,
    W_CHK = 11'b00001000000,
    DIV   = 11'b00010000000,
    P_RD  = 11'b00100000000,
    P_CHK = 11'b01000000000,
    DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [CountW-1:0] entry_count;
  logic [CountW-1:0] n, lo, hi, mid, idx, first, pick;
  logic [CountW-1:0] mid_calc, n_cap;
  logic              best_mode;
  logic [63:0]       key;
  logic [RandW-1:0]  rnd;
  logic [15:0]       best, sel_payload, sel_weight;
  logic [TotW-1:0]   total, r;
  logic [TotW-1:0]   run_total;
  logic [1:0]        res_status;

  logic        in_acc;
  logic        out_load;
  out_item_t   out_next;
  logic        mem_we;
  logic [AW-1:0] raddr;
  entry_t      wdata, rdata;
  logic        div_start;
  div_stat_t   div_stat;
  logic        key_eq, key_gt, last;

  assign in_stall = (state != IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign n_cap    = (entry_count > CountW'(CAP)) ? CountW'(CAP) : entry_count;
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign key_eq   = (rdata.key == key);
  assign key_gt   = (rdata.key > key);
  assign last     = ((idx + CountW'(1)) >= n);
  assign run_total = key_eq ? total + TotW'(rdata.weight) : total;

  assign mem_we      = in_acc && (in_item.opcode == OP_WRITE)
                       && (32'(in_item.slot) < TABLE_DEPTH);
  assign wdata.key     = in_item.search_key;
  assign wdata.payload = in_item.payload;
  assign wdata.weight  = in_item.entry_weight;

  always_comb begin
    case (state)
      S_RD:    raddr = AW'(mid_calc);
      default: raddr = AW'(idx);
    endcase
  end

  ktwp_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_item.slot)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ktwp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rnd),
    .divisor  (run_total),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      IDLE: begin
        if (in_acc && (in_item.opcode == OP_BEST || in_item.opcode == OP_RAND)
            && (n_cap != '0)) begin
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (key_eq) begin
          state_next = (mid == '0) ? W_RD : B_RD;
        end else if (key_gt ? (lo == mid) : (hi == mid)) begin
          state_next = DONE;
        end else begin
          state_next = S_RD;
        end
      end
      B_RD: state_next = B_CHK;
      B_CHK: state_next = (key_eq && idx != '0) ? B_RD : W_RD;
      W_RD: state_next = W_CHK;
      W_CHK: begin
        if (key_eq && !last) begin
          state_next = W_RD;
        end else if (best_mode) begin
          state_next = DONE;
        end else if (run_total == '0) begin
          state_next = DONE;
        end else begin
          state_next = DIV;
          div_start  = 1'b1;
        end
      end
      DIV: if (div_stat.done) state_next = P_RD;
      P_RD: state_next = P_CHK;
      P_CHK: begin
        if ((TotW'(rdata.weight) >= r) || last) begin
          state_next = DONE;
        end else begin
          state_next = P_RD;
        end
      end
      DONE: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        n          <= n_cap;
        lo         <= '0;
        hi         <= n_cap - CountW'(1);
        key        <= in_item.search_key;
        rnd        <= in_item.random_value;
        best_mode  <= (in_item.opcode == OP_BEST);
        res_status <= ST_MISSING;
      end
      S_RD: mid <= mid_calc;
      S_CHK: begin
        if (key_eq) begin
          first <= mid;
          idx   <= (mid == '0) ? mid : mid - CountW'(1);
          if (mid == '0) begin
            best  <= '0;
            total <= '0;
          end
        end else if (key_gt) begin
          hi <= mid - CountW'(1);
        end else begin
          lo <= mid + CountW'(1);
        end
      end
      B_CHK: begin
        if (key_eq) begin
          first <= idx;
        end
        if (key_eq && idx != '0) begin
          idx <= idx - CountW'(1);
        end else begin
          idx   <= key_eq ? idx : first;
          best  <= '0;
          total <= '0;
        end
      end
      W_CHK: begin
        if (key_eq) begin
          if (rdata.weight > best) begin
            best <= rdata.weight;
          end
          if ((idx == first) || (rdata.weight > best)) begin
            pick        <= idx;
            sel_payload <= rdata.payload;
            sel_weight  <= rdata.weight;
          end
          total <= run_total;
          idx   <= idx + CountW'(1);
        end
        if (!(key_eq && !last)) begin
          if (best_mode) begin
            res_status <= ST_FOUND;
          end else if (run_total == '0) begin
            res_status <= ST_ZERO_WEIGHT;
          end
        end
      end
      DIV: begin
        idx <= first;
        r   <= div_stat.rem + TotW'(1);
      end
      P_CHK: begin
        pick        <= idx;
        sel_payload <= rdata.payload;
        sel_weight  <= rdata.weight;
        r           <= r - TotW'(rdata.weight);
        idx         <= idx + CountW'(1);
        if ((TotW'(rdata.weight) >= r) || last) begin
          res_status <= ST_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (in_acc && (in_item.opcode == OP_WRITE)) begin
      out_load        = 1'b1;
      out_next.status = ST_WRITTEN;
    end else if (in_acc && (in_item.opcode == OP_NONE || n_cap == '0)) begin
      out_load        = 1'b1;
      out_next.status = ST_MISSING;
    end else if (state == DONE) begin
      out_load        = 1'b1;
      out_next.status = res_status;
      if (res_status == ST_FOUND) begin
        out_next.chosen_payload = sel_payload;
        out_next.chosen_weight  = sel_weight;
        out_next.chosen_index   = pick[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= out_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ktwp_checker.sv -----
// Port-level checker for the keyed table weighted pick block and its bind.
`default_nettype none
module ktwp_checker
  import ktwp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.opcode == OP_WRITE
    |=> out_valid && out_item.status == ST_WRITTEN)
    else $error("write item not answered next cycle");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_FOUND
    |-> out_item.chosen_payload == '0 && out_item.chosen_weight == '0
        && out_item.chosen_index == '0)
    else $error("nonzero fields on a result that found nothing");

endmodule

bind keyed_table_weighted_pick ktwp_checker u_ktwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
